[design/clns_pkg.sv]
`timescale 1ns / 1ps

package clns_pkg;

    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_W = 16;
    localparam int PHASE_W = 8;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_GAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE    = 3'd4;

    localparam logic [WAIT_W-1:0]  RST_POWER_UP  = 16'd40000;
    localparam logic [WAIT_W-1:0]  RST_WAKE_GAP  = 16'd200;
    localparam logic [WAIT_W-1:0]  RST_CMD_GAP   = 16'd40;
    localparam logic [WAIT_W-1:0]  RST_CLEAR_GAP = 16'd40000;
    localparam logic [PHASE_W-1:0] RST_STROBE    = 8'd5;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_CURSOR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_WAKE,
        GAP_CMD,
        GAP_CLEAR
    } t_gap;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              load_req;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_status;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              reg_select;
        logic [WAIT_W-1:0] wait_before_us;
        logic [WAIT_W-1:0] wait_after_us;
        logic              last;
    } t_result;

    // Nibbles of the power-up sequence: wake 3,3,3, then 2, then the five bytes.
    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        case (step)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd6, 4'd13:      nib = 4'h1;
            4'd9:             nib = 4'hC;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic t_gap init_gap(input logic [STEP_W-1:0] step);
        t_gap gap;
        case (step)
            4'd0, 4'd1, 4'd2:                  gap = GAP_WAKE;
            4'd3, 4'd5, 4'd7, 4'd9, 4'd11:     gap = GAP_CMD;
            4'd13:                             gap = GAP_CLEAR;
            default:                           gap = GAP_NONE;
        endcase
        return gap;
    endfunction

endpackage

[design/clns_in_if.sv]
`timescale 1ns / 1ps

interface clns_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;

    modport source (output valid, output mode, output byte_value, output column,
                    output row, input ready);
    modport sink (input valid, input mode, input byte_value, input column,
                  input row, output ready);
endinterface

[design/clns_out_if.sv]
`timescale 1ns / 1ps

interface clns_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  nibble;
    logic        reg_select;
    logic [15:0] wait_before_us;
    logic [15:0] wait_after_us;
    logic        last;

    modport source (output valid, output nibble, output reg_select,
                    output wait_before_us, output wait_after_us, output last,
                    input ready);
    modport sink (input valid, input nibble, input reg_select,
                  input wait_before_us, input wait_after_us, input last,
                  output ready);
endinterface

[design/char_lcd_nibble_sequencer_unit.sv]
`timescale 1ns / 1ps
// The first nibble is registered in the run state that follows acceptance of the request.
// Throughput: one nibble per cycle while the sink takes them; init gives 14
// nibbles, other requests 2; the next request is taken in the idle state after the last.
// The step counter of the controller sets the rate: one table step per cycle while the sink takes them.
// Reset: synchronous, active low; config and control registers reset, sequencer idles.
module char_lcd_nibble_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    clns_in_if.sink                         i_req,
    clns_out_if.source                      o_res
);
    import clns_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_result    result;

    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    clns_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_req.mode),
        .i_byte_value (i_req.byte_value),
        .i_column     (i_req.column),
        .i_row        (i_req.row),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_result     (result)
    );

    assign o_res.nibble         = result.nibble;
    assign o_res.reg_select     = result.reg_select;
    assign o_res.wait_before_us = result.wait_before_us;
    assign o_res.wait_after_us  = result.wait_after_us;
    assign o_res.last           = result.last;

endmodule

[design/clns_ctrl.sv]
`timescale 1ns / 1ps

module clns_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  clns_pkg::t_dp_status i_status,
    output clns_pkg::t_ctrl_cmd  o_cmd
);
    import clns_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_out_valid    = r_out_valid;
        o_cmd.load_req = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.step     = r_step;
        o_in_ready     = 1'b0;

        // drop the held result once its transaction completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_step         = '0;
                    n_state        = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_step         = r_step + 1'b1;
                    if (i_status.last_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/clns_dpath.sv]
`timescale 1ns / 1ps

module clns_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clns_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                       i_mode,
    input  logic [7:0]                       i_byte_value,
    input  logic [5:0]                       i_column,
    input  logic                             i_row,
    input  clns_pkg::t_ctrl_cmd              i_cmd,
    output clns_pkg::t_dp_status             o_status,
    output clns_pkg::t_result                o_result
);
    import clns_pkg::*;

    logic [WAIT_W-1:0]  r_power_up, r_wake_gap, r_cmd_gap, r_clear_gap;
    logic [PHASE_W-1:0] r_strobe;
    t_mode              r_mode;
    logic [7:0]         r_byte;
    t_result            r_result;

    logic [7:0] cursor_addr;
    t_result    n_result;
    t_gap       gap;
    logic       is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_up  <= RST_POWER_UP;
            r_wake_gap  <= RST_WAKE_GAP;
            r_cmd_gap   <= RST_CMD_GAP;
            r_clear_gap <= RST_CLEAR_GAP;
            r_strobe    <= RST_STROBE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POWER_UP:  r_power_up  <= i_cfg_data;
                CFG_WAKE_GAP:  r_wake_gap  <= i_cfg_data;
                CFG_CMD_GAP:   r_cmd_gap   <= i_cfg_data;
                CFG_CLEAR_GAP: r_clear_gap <= i_cfg_data;
                CFG_STROBE:    r_strobe    <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cursor_addr = CURSOR_BASE + {2'b00, i_column} + (i_row ? LINE2_OFFSET : 8'h00);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= t_mode'(i_mode);
            r_byte <= (t_mode'(i_mode) == MODE_CURSOR) ? cursor_addr : i_byte_value;
        end
        if (i_cmd.load_out) begin
            r_result <= n_result;
        end
    end

    assign is_last = (r_mode == MODE_INIT) ? (i_cmd.step == INIT_LAST_STEP)
                                           : (i_cmd.step == BYTE_LAST_STEP);
    assign gap = init_gap(i_cmd.step);

    always_comb begin
        n_result.last       = is_last;
        n_result.reg_select = (r_mode == MODE_DATA);
        n_result.wait_before_us = '0;
        n_result.wait_after_us  = '0;
        if (r_mode == MODE_INIT) begin
            n_result.nibble = init_nibble(i_cmd.step);
            if (i_cmd.step == '0) begin
                n_result.wait_before_us = r_power_up;
            end
            case (gap)
                GAP_WAKE:  n_result.wait_after_us = r_wake_gap;
                GAP_CMD:   n_result.wait_after_us = r_cmd_gap;
                GAP_CLEAR: n_result.wait_after_us = r_clear_gap;
                default:   n_result.wait_after_us = '0;
            endcase
        end else begin
            // high nibble first; data holds RS setup before it
            n_result.nibble = i_cmd.step[0] ? r_byte[3:0] : r_byte[7:4];
            if (r_mode == MODE_DATA && !i_cmd.step[0]) begin
                n_result.wait_before_us = {{(WAIT_W-PHASE_W){1'b0}}, r_strobe};
            end
        end
    end

    assign o_status.last_step = is_last;
    assign o_result           = r_result;

endmodule
